/* sv/xxtea_pkg.sv */
// ----------------------------------------------------------------------------
// xxtea_pkg
// Shared constants, types and functions of the XXTEA block cipher: register
// map, configuration bundle, round count table and the MX mix function.
// ----------------------------------------------------------------------------
package xxtea_pkg;

    // Word store geometry
    localparam int MAX_WORDS = 64;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);

    // Register file geometry
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 5;
    localparam int WORDS_W   = 7;
    localparam int ROUND_W   = 6;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_WORDS = 3'd4;
    localparam logic [2:0] REG_MODE  = 3'd5;

    localparam logic [WORDS_W-1:0] WORDS_RESET = WORDS_W'(64);
    localparam logic [31:0]        TEA_DELTA   = 32'h9e37_79b9;

    typedef logic [3:0][31:0] t_key;

    // Configuration as seen by the datapath
    typedef struct packed {
        t_key             key;
        logic [CNT_W-1:0] words;    // effective block size, 2..MAX_WORDS
        logic             decrypt;
    } t_cfg;

    // Rounds = 6 + 52/n, written as a compare chain over the block size
    function automatic logic [ROUND_W-1:0] rounds_for(input logic [CNT_W-1:0] n);
        logic [ROUND_W-1:0] r;
        if      (n >= CNT_W'(53)) r = ROUND_W'(6);
        else if (n >= CNT_W'(27)) r = ROUND_W'(7);
        else if (n >= CNT_W'(18)) r = ROUND_W'(8);
        else if (n >= CNT_W'(14)) r = ROUND_W'(9);
        else if (n >= CNT_W'(11)) r = ROUND_W'(10);
        else if (n >= CNT_W'(9))  r = ROUND_W'(11);
        else if (n == CNT_W'(8))  r = ROUND_W'(12);
        else if (n == CNT_W'(7))  r = ROUND_W'(13);
        else if (n == CNT_W'(6))  r = ROUND_W'(14);
        else if (n == CNT_W'(5))  r = ROUND_W'(16);
        else if (n == CNT_W'(4))  r = ROUND_W'(19);
        else if (n == CNT_W'(3))  r = ROUND_W'(23);
        else                      r = ROUND_W'(32);
        return r;
    endfunction

    // MX mix of XXTEA
    function automatic logic [31:0] mix(input logic [31:0] z,
                                        input logic [31:0] y,
                                        input logic [31:0] sum,
                                        input logic [1:0]  p,
                                        input logic [1:0]  e,
                                        input t_key        key);
        logic [31:0] a;
        logic [31:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (key[p ^ e] ^ z);
        return a ^ b;
    endfunction

endpackage

/* sv/xxtea_ram.sv */
// ----------------------------------------------------------------------------
// xxtea_ram
// Word store: one write port, one read port, registered read data,
// read-first when both ports hit the same entry.
// ----------------------------------------------------------------------------
module xxtea_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [xxtea_pkg::ADDR_W-1:0] i_waddr,
    input  logic [31:0]                 i_wdata,
    input  logic                        i_re,
    input  logic [xxtea_pkg::ADDR_W-1:0] i_raddr,
    output logic [31:0]                 o_rdata
);
    import xxtea_pkg::*;

    logic [31:0] r_mem [MAX_WORDS];
    logic [31:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/xxtea_regs.sv */
// ----------------------------------------------------------------------------
// xxtea_regs
// APB register file: four key words, block size and mode. Presents the
// clamped block size and the key to the datapath as one bundle.
// ----------------------------------------------------------------------------
module xxtea_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [xxtea_pkg::PADDR_W-1:0] paddr,
    input  logic [xxtea_pkg::DATA_W-1:0] pwdata,
    output logic [xxtea_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output xxtea_pkg::t_cfg              o_cfg
);
    import xxtea_pkg::*;

    t_key               r_key;
    logic [WORDS_W-1:0] r_words;
    logic               r_mode;
    logic [2:0]         reg_idx;
    logic               wr_en;
    logic [CNT_W-1:0]   words_ext;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_words <= WORDS_RESET;
            r_mode  <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KEY0:  r_key[0] <= pwdata;
                REG_KEY1:  r_key[1] <= pwdata;
                REG_KEY2:  r_key[2] <= pwdata;
                REG_KEY3:  r_key[3] <= pwdata;
                REG_WORDS: r_words  <= pwdata[WORDS_W-1:0];
                REG_MODE:  r_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_KEY0:  prdata = r_key[0];
            REG_KEY1:  prdata = r_key[1];
            REG_KEY2:  prdata = r_key[2];
            REG_KEY3:  prdata = r_key[3];
            REG_WORDS: prdata = DATA_W'(r_words);
            REG_MODE:  prdata = DATA_W'(r_mode);
            default:   prdata = '0;
        endcase
    end

    // Clamp block size into 2..MAX_WORDS
    assign words_ext = CNT_W'(r_words);

    always_comb begin
        o_cfg.key     = r_key;
        o_cfg.decrypt = r_mode;
        if (words_ext < CNT_W'(2)) begin
            o_cfg.words = CNT_W'(2);
        end else if (words_ext > CNT_W'(MAX_WORDS)) begin
            o_cfg.words = CNT_W'(MAX_WORDS);
        end else begin
            o_cfg.words = words_ext;
        end
    end

endmodule

/* sv/xxtea_core.sv */
// ----------------------------------------------------------------------------
// xxtea_core
// Load, round and emit sequencer around the word store. Each round step
// reads the neighbor word, mixes it with the carried word and writes the
// updated word back; a one-entry bypass covers the two-word block case.
// ----------------------------------------------------------------------------
module xxtea_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xxtea_pkg::t_cfg i_cfg,
    input  logic            start,
    input  logic [31:0]     i_data_word,
    output logic            busy,
    output logic            o_valid,
    output logic [31:0]     o_result_word,
    output logic            o_last_word
);
    import xxtea_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP0 = 3'd1;
    localparam logic [2:0] S_PREP1 = 3'd2;
    localparam logic [2:0] S_PREP2 = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]         r_state;
    logic [ADDR_W-1:0]  r_load_cnt;
    logic [ADDR_W-1:0]  r_idx;
    logic [ROUND_W-1:0] r_rounds;
    logic [31:0]        r_sum;
    logic [31:0]        r_carry;
    logic [31:0]        r_cur;
    logic               r_dec;
    logic               r_fwd_hit;
    logic [31:0]        r_fwd_data;
    logic               r_out_valid;
    logic               r_out_last;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [31:0]        mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [31:0]        mem_rdata;

    logic [ADDR_W-1:0]  last_idx;
    logic [ROUND_W-1:0] rounds;
    logic               accept;
    logic               block_full;
    logic [31:0]        nb_val;
    logic [31:0]        mx_z;
    logic [31:0]        mx_y;
    logic [31:0]        mx;
    logic [31:0]        new_val;
    logic [ADDR_W-1:0]  idx_next;
    logic [ADDR_W-1:0]  nb_first;
    logic [ADDR_W-1:0]  nb_next;
    logic               end_round;

    xxtea_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign last_idx   = ADDR_W'(i_cfg.words - CNT_W'(1));
    assign rounds     = rounds_for(i_cfg.words);
    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign block_full = (CNT_W'(r_load_cnt) + CNT_W'(1)) >= i_cfg.words;

    // Neighbor of the current step (used when priming) and next step index
    always_comb begin
        if (r_dec) begin
            nb_first = (r_idx == '0) ? last_idx : r_idx - ADDR_W'(1);
            idx_next = (r_idx == '0) ? last_idx : r_idx - ADDR_W'(1);
            nb_next  = (idx_next == '0) ? last_idx : idx_next - ADDR_W'(1);
            end_round = (r_idx == '0);
        end else begin
            nb_first = (r_idx == last_idx) ? '0 : r_idx + ADDR_W'(1);
            idx_next = (r_idx == last_idx) ? '0 : r_idx + ADDR_W'(1);
            nb_next  = (idx_next == last_idx) ? '0 : idx_next + ADDR_W'(1);
            end_round = (r_idx == last_idx);
        end
    end

    // Mix datapath
    assign nb_val  = r_fwd_hit ? r_fwd_data : mem_rdata;
    assign mx_z    = r_dec ? nb_val : r_carry;
    assign mx_y    = r_dec ? r_carry : nb_val;
    assign mx      = mix(mx_z, mx_y, r_sum, r_idx[1:0], r_sum[3:2], i_cfg.key);
    assign new_val = r_dec ? (r_cur - mx) : (r_cur + mx);

    // Memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = new_val;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                mem_we    = accept;
                mem_waddr = r_load_cnt;
                mem_wdata = i_data_word;
            end
            S_PREP0: begin
                mem_re    = 1'b1;
                mem_raddr = i_cfg.decrypt ? '0 : last_idx;
            end
            S_PREP1: begin
                mem_re    = 1'b1;
                mem_raddr = r_dec ? last_idx : '0;
            end
            S_PREP2: begin
                mem_re    = 1'b1;
                mem_raddr = nb_first;
            end
            S_RUN: begin
                mem_we    = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = nb_next;
            end
            S_EMIT: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
            end
            default: ;
        endcase
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_cnt  <= '0;
            r_idx       <= '0;
            r_rounds    <= '0;
            r_sum       <= '0;
            r_dec       <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    // Count words in; start the block when full
                    if (accept) begin
                        if (block_full) begin
                            r_load_cnt <= '0;
                            r_state    <= S_PREP0;
                        end else begin
                            r_load_cnt <= r_load_cnt + ADDR_W'(1);
                        end
                    end
                end
                S_PREP0: begin
                    // Sample mode, set round count and starting sum
                    r_dec    <= i_cfg.decrypt;
                    r_rounds <= rounds;
                    r_sum    <= i_cfg.decrypt ?
                                32'(32'(rounds) * TEA_DELTA) : TEA_DELTA;
                    r_idx    <= i_cfg.decrypt ? last_idx : '0;
                    r_state  <= S_PREP1;
                end
                S_PREP1: begin
                    r_state <= S_PREP2;
                end
                S_PREP2: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    // One word update per cycle; bypass a write to the entry just read
                    r_fwd_hit <= (nb_next == r_idx);
                    r_idx     <= idx_next;
                    if (end_round) begin
                        r_rounds <= r_rounds - ROUND_W'(1);
                        r_sum    <= r_dec ? (r_sum - TEA_DELTA) : (r_sum + TEA_DELTA);
                        if (r_rounds == ROUND_W'(1)) begin
                            r_idx   <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    // Stream the block out, one word per cycle
                    r_out_valid <= 1'b1;
                    r_out_last  <= (r_idx == last_idx);
                    if (r_idx == last_idx) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + ADDR_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Word registers around the mix
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_PREP1: r_carry <= mem_rdata;
            S_PREP2: r_cur   <= mem_rdata;
            S_RUN: begin
                r_carry    <= new_val;
                r_cur      <= nb_val;
                r_fwd_data <= new_val;
            end
            default: ;
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_last_word   = r_out_last;
    assign o_result_word = mem_rdata;

    // Output words only follow the emit phase
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_EMIT))
        else $error("result strobe without emit phase");

    // The store is written only while loading or running rounds
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE) || (r_state == S_RUN))
        else $error("store write outside load or round phase");

    // A round step never runs with no rounds left
    a_rounds_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_rounds != '0))
        else $error("round step with zero rounds left");

    // Bypass is needed only for two-word blocks
    a_fwd_two_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> $past(i_cfg.words == CNT_W'(2)))
        else $error("bypass hit on a block larger than two words");

    // Last-word flag is only raised together with the strobe
    a_last_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_last) |-> r_out_valid && $past(r_state == S_EMIT))
        else $error("last-word flag outside a result cycle");

endmodule

/* sv/xxtea_block_cipher.sv */
// ----------------------------------------------------------------------------
// xxtea_block_cipher
// XXTEA block encrypt/decrypt over a block of 2..64 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Configure key words, block size and mode over the APB port while idle
//   (registers at byte addresses 0,4,..,20; pready is always high).
//   Feed one data word per cycle with start; a word is taken when start is
//   high and busy is low.
//   After the n-th word is taken, busy rises for the whole block: a priming
//   phase, then (6 + 52/n) rounds of n word updates at one update per cycle
//   through the word store's separate read and write ports, then the output
//   phase. Result words appear with o_valid for one cycle each, index zero
//   first, o_last_word on the final one; the receiver cannot stall them.
//   Reset clears the registers to key zero, 64 words, encrypt, and drops any
//   partly loaded block; the store itself is not cleared.
// ----------------------------------------------------------------------------
module xxtea_block_cipher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [xxtea_pkg::PADDR_W-1:0] paddr,
    input  logic [xxtea_pkg::DATA_W-1:0] pwdata,
    output logic [xxtea_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         start,
    input  logic [31:0]                  i_data_word,
    output logic                         busy,
    output logic                         o_valid,
    output logic [31:0]                  o_result_word,
    output logic                         o_last_word
);
    import xxtea_pkg::*;

    t_cfg cfg;

    xxtea_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    xxtea_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .start         (start),
        .i_data_word   (i_data_word),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_result_word (o_result_word),
        .o_last_word   (o_last_word)
    );

endmodule
